// ----- sv/gcp_pkg.sv -----
// ----------------------------------------------------------------------------
// gcp_pkg
// Shared types, widths, constants and the cursor bitmap of the gradient
// cursor pixel generator.
// ----------------------------------------------------------------------------
package gcp_pkg;

    localparam int COL_W     = 12;
    localparam int CFG_W     = 13;
    localparam int DIAG_W    = 13;
    localparam int SPAN_W    = 14;
    localparam int DIFF_W    = 15;
    localparam int NUM_W     = 22;
    localparam int HUE_W     = 9;
    localparam int DIV_STEPS = HUE_W;
    localparam int IDX_W     = 3;
    localparam int REM_W     = 6;
    localparam int CH_W      = 8;
    localparam int ARGB_W    = 32;

    localparam int CURSOR_W  = 8;
    localparam int CURSOR_H  = 12;
    localparam int CUR_X_W   = $clog2(CURSOR_W);
    localparam int CUR_Y_W   = $clog2(CURSOR_H);

    localparam int HUE_FULL    = 360;
    localparam int SECTOR_SPAN = 60;

    // 255/60 equals 17/4, and x*204/255 equals x*4/5, taken as x*820 >> 10.
    localparam int FRAC_MUL    = 17;
    localparam int FRAC_SHIFT  = 2;
    localparam int SCALE_W     = 18;
    localparam int SCALE_MUL   = 820;
    localparam int SCALE_SHIFT = 10;

    localparam logic [CH_W-1:0]   CH_VALUE   = 8'd204;
    localparam logic [CH_W-1:0]   CH_FULL    = 8'd255;
    localparam logic [CH_W-1:0]   CH_ALPHA   = 8'hFF;
    localparam logic [ARGB_W-1:0] ARGB_WHITE = 32'hFFFF_FFFF;
    localparam logic [ARGB_W-1:0] ARGB_BLACK = 32'hFF00_0000;

    localparam logic [IDX_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CCOL   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_CROW   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_CEN    = 3'd4;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd480;
    localparam logic [CFG_W-1:0] RST_CCOL   = 13'd320;
    localparam logic [CFG_W-1:0] RST_CROW   = 13'd240;

    typedef enum logic [1:0] {
        CELL_CLR = 2'd0,
        CELL_WHT = 2'd1,
        CELL_BLK = 2'd2
    } t_cell;

    typedef enum logic [2:0] {
        SEC_R2Y = 3'd0,
        SEC_Y2G = 3'd1,
        SEC_G2C = 3'd2,
        SEC_C2B = 3'd3,
        SEC_B2M = 3'd4,
        SEC_M2R = 3'd5
    } t_sector;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [CFG_W-1:0] ccol;
        logic [CFG_W-1:0] crow;
        logic             cen;
    } t_cfg;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic             over;
        t_cell            arrow;
    } t_front_out;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [HUE_W-1:0] quo;
        logic             over;
        t_cell            arrow;
    } t_div_stage;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic             over;
        t_cell            arrow;
    } t_div_out;

    localparam t_cell ARROW_MAP [CURSOR_H][CURSOR_W] = '{
        '{CELL_WHT, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR},
        '{CELL_WHT, CELL_WHT, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR},
        '{CELL_WHT, CELL_BLK, CELL_WHT, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR},
        '{CELL_WHT, CELL_BLK, CELL_BLK, CELL_WHT, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR},
        '{CELL_WHT, CELL_BLK, CELL_BLK, CELL_BLK, CELL_WHT, CELL_CLR, CELL_CLR, CELL_CLR},
        '{CELL_WHT, CELL_BLK, CELL_BLK, CELL_BLK, CELL_BLK, CELL_WHT, CELL_CLR, CELL_CLR},
        '{CELL_WHT, CELL_BLK, CELL_BLK, CELL_BLK, CELL_BLK, CELL_BLK, CELL_WHT, CELL_CLR},
        '{CELL_WHT, CELL_BLK, CELL_BLK, CELL_BLK, CELL_BLK, CELL_WHT, CELL_WHT, CELL_WHT},
        '{CELL_WHT, CELL_BLK, CELL_BLK, CELL_WHT, CELL_WHT, CELL_CLR, CELL_CLR, CELL_CLR},
        '{CELL_WHT, CELL_WHT, CELL_BLK, CELL_WHT, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR},
        '{CELL_CLR, CELL_CLR, CELL_WHT, CELL_WHT, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR},
        '{CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR, CELL_CLR}
    };

endpackage

// ----- sv/gradient_cursor_pixel_gen.sv -----
// ----------------------------------------------------------------------------
// gradient_cursor_pixel_gen
// Diagonal rainbow background with an arrow cursor overlay, one ARGB
// pixel per screen coordinate.
// ----------------------------------------------------------------------------
// Coordinates enter on a valid/ready channel (i_valid, o_ready) and each
// transfer yields exactly one colour on the output channel (o_valid,
// i_ready), in order. The pipeline has 13 register stages: two front
// stages for the cursor lookup and the scaled diagonal, nine divider
// stages that each settle one bit of the hue, and two colour stages, the
// last being the output register. A new pixel can be taken every cycle
// unless the full pipeline is held by a stalled receiver; the divider stages set the depth.
// Each stage holds its item while the stage after it is full and stalled,
// so a stalled receiver first fills the empty stages and then holds
// o_ready low; nothing is dropped or repeated. The configuration port
// writes one register per cycle with i_cfg_we; indexes past the last
// register are ignored. Reset empties the pipeline and loads the register
// defaults: 640 by 480 screen, cursor at column 320, row 240, enabled.
// ----------------------------------------------------------------------------
module gradient_cursor_pixel_gen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gcp_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [gcp_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [gcp_pkg::COL_W-1:0]   i_pixel_col,
    input  logic [gcp_pkg::COL_W-1:0]   i_pixel_row,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [gcp_pkg::ARGB_W-1:0]  o_pixel_argb
);

    gcp_pkg::t_cfg                r_cfg;
    logic [gcp_pkg::SPAN_W-1:0]   w_span;
    logic                         w_f_valid;
    logic                         w_f_ready;
    gcp_pkg::t_front_out          w_f_data;
    logic                         w_d_valid;
    logic                         w_d_ready;
    gcp_pkg::t_div_out            w_d_data;

    assign w_span = {1'b0, r_cfg.width} + {1'b0, r_cfg.height};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= gcp_pkg::RST_WIDTH;
            r_cfg.height <= gcp_pkg::RST_HEIGHT;
            r_cfg.ccol   <= gcp_pkg::RST_CCOL;
            r_cfg.crow   <= gcp_pkg::RST_CROW;
            r_cfg.cen    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gcp_pkg::CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                gcp_pkg::CFG_HEIGHT: r_cfg.height <= i_cfg_data;
                gcp_pkg::CFG_CCOL:   r_cfg.ccol   <= i_cfg_data;
                gcp_pkg::CFG_CROW:   r_cfg.crow   <= i_cfg_data;
                gcp_pkg::CFG_CEN:    r_cfg.cen    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    gcp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_span  (w_span),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_col   (i_pixel_col),
        .i_row   (i_pixel_row),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_data  (w_f_data)
    );

    gcp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_span  (w_span),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_data),
        .o_valid (w_d_valid),
        .i_ready (w_d_ready),
        .o_data  (w_d_data)
    );

    gcp_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .o_ready (w_d_ready),
        .i_data  (w_d_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_argb  (o_pixel_argb)
    );

endmodule

// ----- sv/gcp_front.sv -----
// ----------------------------------------------------------------------------
// gcp_front
// Two stages: cursor bitmap lookup and diagonal sum, then the scaled
// diagonal for the hue divider and the out-of-range hue flag.
// ----------------------------------------------------------------------------
module gcp_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gcp_pkg::t_cfg              i_cfg,
    input  logic [gcp_pkg::SPAN_W-1:0] i_span,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [gcp_pkg::COL_W-1:0]  i_col,
    input  logic [gcp_pkg::COL_W-1:0]  i_row,
    output logic                       o_valid,
    input  logic                       i_ready,
    output gcp_pkg::t_front_out        o_data
);

    logic                         r_v1;
    logic [gcp_pkg::DIAG_W-1:0]   r_diag;
    gcp_pkg::t_cell               r_cell;
    logic                         r_v2;
    gcp_pkg::t_front_out          r_out;

    logic                         w_en1;
    logic                         w_en2;
    logic [gcp_pkg::DIAG_W-1:0]   n_diag;
    gcp_pkg::t_cell               n_cell;
    gcp_pkg::t_front_out          n_out;
    logic [gcp_pkg::DIFF_W-1:0]   w_dx;
    logic [gcp_pkg::DIFF_W-1:0]   w_dy;
    logic                         w_hit;

    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v2;
    assign o_data  = r_out;

    always_comb begin
        n_diag = {1'b0, i_col} + {1'b0, i_row};
        w_dx   = {3'b000, i_col} - {{2{i_cfg.ccol[gcp_pkg::CFG_W-1]}}, i_cfg.ccol};
        w_dy   = {3'b000, i_row} - {{2{i_cfg.crow[gcp_pkg::CFG_W-1]}}, i_cfg.crow};
        w_hit  = i_cfg.cen
              && ({1'b0, i_col} < i_cfg.width)
              && ({1'b0, i_row} < i_cfg.height)
              && (w_dx[gcp_pkg::DIFF_W-1:gcp_pkg::CUR_X_W] == '0)
              && (w_dy[gcp_pkg::DIFF_W-1:gcp_pkg::CUR_Y_W] == '0)
              && (w_dy[gcp_pkg::CUR_Y_W-1:0] < gcp_pkg::CUR_Y_W'(gcp_pkg::CURSOR_H));
        n_cell = gcp_pkg::CELL_CLR;
        if (w_hit) begin
            n_cell = gcp_pkg::ARROW_MAP[w_dy[gcp_pkg::CUR_Y_W-1:0]]
                                       [w_dx[gcp_pkg::CUR_X_W-1:0]];
        end
    end

    always_comb begin
        n_out.num   = gcp_pkg::NUM_W'(r_diag) * gcp_pkg::NUM_W'(gcp_pkg::HUE_FULL);
        n_out.over  = {1'b0, r_diag} >= i_span;
        n_out.arrow = r_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_diag <= n_diag;
            r_cell <= n_cell;
        end
        if (w_en2) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- sv/gcp_div.sv -----
// ----------------------------------------------------------------------------
// gcp_div
// Pipelined restoring divider: one quotient bit of the hue per stage.
// ----------------------------------------------------------------------------
module gcp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [gcp_pkg::SPAN_W-1:0] i_span,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  gcp_pkg::t_front_out        i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output gcp_pkg::t_div_out          o_data
);

    localparam int LAST = gcp_pkg::DIV_STEPS - 1;

    logic                r_v [gcp_pkg::DIV_STEPS];
    gcp_pkg::t_div_stage r_d [gcp_pkg::DIV_STEPS];
    logic                w_en [gcp_pkg::DIV_STEPS+1];

    assign w_en[gcp_pkg::DIV_STEPS] = i_ready;
    assign o_ready = w_en[0];
    assign o_valid = r_v[LAST];
    assign o_data  = '{hue: r_d[LAST].quo, over: r_d[LAST].over, arrow: r_d[LAST].arrow};

    for (genvar g = 0; g < gcp_pkg::DIV_STEPS; g++) begin : g_step
        localparam int SH = gcp_pkg::DIV_STEPS - 1 - g;

        gcp_pkg::t_div_stage        w_src;
        logic                       w_src_v;
        logic [gcp_pkg::NUM_W-1:0]  w_dsh;
        gcp_pkg::t_div_stage        n_d;

        if (g == 0) begin : g_first
            assign w_src   = '{rem: i_data.num, quo: '0, over: i_data.over,
                               arrow: i_data.arrow};
            assign w_src_v = i_valid;
        end else begin : g_next
            assign w_src   = r_d[g-1];
            assign w_src_v = r_v[g-1];
        end

        assign w_en[g] = !r_v[g] || w_en[g+1];
        assign w_dsh   = gcp_pkg::NUM_W'(i_span) << SH;

        always_comb begin
            n_d = w_src;
            if (w_src.rem >= w_dsh) begin
                n_d.rem     = w_src.rem - w_dsh;
                n_d.quo[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (w_en[g]) begin
                r_v[g] <= w_src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[g]) begin
                r_d[g] <= n_d;
            end
        end
    end

endmodule

// ----- sv/gcp_color.sv -----
// ----------------------------------------------------------------------------
// gcp_color
// Two stages: hue to sector and fraction, then channel scaling, sector
// selection, out-of-range override and cursor compositing into the output register.
// ----------------------------------------------------------------------------
module gcp_color (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  gcp_pkg::t_div_out           i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [gcp_pkg::ARGB_W-1:0]  o_argb
);

    logic                          r_v1;
    gcp_pkg::t_sector              r_sec;
    logic [gcp_pkg::CH_W-1:0]      r_frac;
    logic                          r_over;
    gcp_pkg::t_cell                r_cell;
    logic                          r_v2;
    logic [gcp_pkg::ARGB_W-1:0]    r_argb;

    logic                          w_en1;
    logic                          w_en2;
    gcp_pkg::t_sector              n_sec;
    logic [gcp_pkg::HUE_W-1:0]     w_base;
    logic [gcp_pkg::REM_W-1:0]     w_rem;
    logic [gcp_pkg::SCALE_W-1:0]   w_frac_x;
    logic [gcp_pkg::CH_W-1:0]      n_frac;
    logic [gcp_pkg::SCALE_W-1:0]   w_t_x;
    logic [gcp_pkg::SCALE_W-1:0]   w_q_x;
    logic [gcp_pkg::CH_W-1:0]      w_t;
    logic [gcp_pkg::CH_W-1:0]      w_q;
    logic [gcp_pkg::CH_W-1:0]      w_r;
    logic [gcp_pkg::CH_W-1:0]      w_g;
    logic [gcp_pkg::CH_W-1:0]      w_b;
    logic [gcp_pkg::ARGB_W-1:0]    n_argb;

    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v2;
    assign o_argb  = r_argb;

    always_comb begin
        if (i_data.hue >= gcp_pkg::HUE_W'(5 * gcp_pkg::SECTOR_SPAN)) begin
            n_sec  = gcp_pkg::SEC_M2R;
            w_base = gcp_pkg::HUE_W'(5 * gcp_pkg::SECTOR_SPAN);
        end else if (i_data.hue >= gcp_pkg::HUE_W'(4 * gcp_pkg::SECTOR_SPAN)) begin
            n_sec  = gcp_pkg::SEC_B2M;
            w_base = gcp_pkg::HUE_W'(4 * gcp_pkg::SECTOR_SPAN);
        end else if (i_data.hue >= gcp_pkg::HUE_W'(3 * gcp_pkg::SECTOR_SPAN)) begin
            n_sec  = gcp_pkg::SEC_C2B;
            w_base = gcp_pkg::HUE_W'(3 * gcp_pkg::SECTOR_SPAN);
        end else if (i_data.hue >= gcp_pkg::HUE_W'(2 * gcp_pkg::SECTOR_SPAN)) begin
            n_sec  = gcp_pkg::SEC_G2C;
            w_base = gcp_pkg::HUE_W'(2 * gcp_pkg::SECTOR_SPAN);
        end else if (i_data.hue >= gcp_pkg::HUE_W'(gcp_pkg::SECTOR_SPAN)) begin
            n_sec  = gcp_pkg::SEC_Y2G;
            w_base = gcp_pkg::HUE_W'(gcp_pkg::SECTOR_SPAN);
        end else begin
            n_sec  = gcp_pkg::SEC_R2Y;
            w_base = '0;
        end
        w_rem    = gcp_pkg::REM_W'(i_data.hue - w_base);
        w_frac_x = gcp_pkg::SCALE_W'(w_rem) * gcp_pkg::SCALE_W'(gcp_pkg::FRAC_MUL);
        n_frac   = gcp_pkg::CH_W'(w_frac_x >> gcp_pkg::FRAC_SHIFT);
    end

    always_comb begin
        w_t_x = gcp_pkg::SCALE_W'(r_frac) * gcp_pkg::SCALE_W'(gcp_pkg::SCALE_MUL);
        w_q_x = gcp_pkg::SCALE_W'(gcp_pkg::CH_FULL - r_frac)
              * gcp_pkg::SCALE_W'(gcp_pkg::SCALE_MUL);
        w_t   = gcp_pkg::CH_W'(w_t_x >> gcp_pkg::SCALE_SHIFT);
        w_q   = gcp_pkg::CH_W'(w_q_x >> gcp_pkg::SCALE_SHIFT);
        case (r_sec)
            gcp_pkg::SEC_R2Y: begin
                w_r = gcp_pkg::CH_VALUE; w_g = w_t;              w_b = '0;
            end
            gcp_pkg::SEC_Y2G: begin
                w_r = w_q;               w_g = gcp_pkg::CH_VALUE; w_b = '0;
            end
            gcp_pkg::SEC_G2C: begin
                w_r = '0;                w_g = gcp_pkg::CH_VALUE; w_b = w_t;
            end
            gcp_pkg::SEC_C2B: begin
                w_r = '0;                w_g = w_q;              w_b = gcp_pkg::CH_VALUE;
            end
            gcp_pkg::SEC_B2M: begin
                w_r = w_t;               w_g = '0;               w_b = gcp_pkg::CH_VALUE;
            end
            gcp_pkg::SEC_M2R: begin
                w_r = gcp_pkg::CH_VALUE; w_g = '0;               w_b = w_q;
            end
            default: begin
                w_r = gcp_pkg::CH_VALUE; w_g = '0;               w_b = '0;
            end
        endcase
        if (r_over) begin
            w_r = gcp_pkg::CH_VALUE;
            w_g = '0;
            w_b = '0;
        end
        case (r_cell)
            gcp_pkg::CELL_WHT: n_argb = gcp_pkg::ARGB_WHITE;
            gcp_pkg::CELL_BLK: n_argb = gcp_pkg::ARGB_BLACK;
            default:           n_argb = {gcp_pkg::CH_ALPHA, w_r, w_g, w_b};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_sec  <= n_sec;
            r_frac <= n_frac;
            r_over <= i_data.over;
            r_cell <= i_data.arrow;
        end
        if (w_en2) begin
            r_argb <= n_argb;
        end
    end

endmodule
